/* rtl/upil_pkg.sv */
// shared types and constants for the unicycle pose integrator
package upil_pkg;

  localparam int unsigned MUL_W = 32;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_CMD   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY = 2'd0,
    CFG_DEAD  = 2'd1,
    CFG_TICK  = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_idx_e;

  typedef logic signed [15:0] lin_t;
  typedef logic signed [23:0] turn_t;
  typedef logic signed [31:0] pos_t;

endpackage

/* rtl/upil_cmd_if.sv */
// command channel carrying one input word
interface upil_cmd_if;
  logic              valid;
  logic              ready;
  upil_pkg::action_e action;
  upil_pkg::lin_t    lin_speed_cmd;
  upil_pkg::turn_t   turn_rate_cmd;

  modport source (output valid, action, lin_speed_cmd, turn_rate_cmd, input ready);
  modport sink   (input valid, action, lin_speed_cmd, turn_rate_cmd, output ready);
endinterface

/* rtl/upil_res_if.sv */
// result channel carrying pose and speeds
interface upil_res_if;
  logic            valid;
  logic            ready;
  upil_pkg::pos_t  pos_x;
  upil_pkg::pos_t  pos_y;
  upil_pkg::pos_t  heading;
  upil_pkg::lin_t  lin_speed_now;
  upil_pkg::turn_t turn_rate_now;

  modport source (output valid, pos_x, pos_y, heading, lin_speed_now, turn_rate_now,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, lin_speed_now, turn_rate_now,
                  output ready);
endinterface

/* rtl/upil_mul.sv */
// shared unsigned multiplier with registered product
module upil_mul (
  input  logic                           clk_i,
  input  logic [upil_pkg::MUL_W-1:0]     a_i,
  input  logic [upil_pkg::MUL_W-1:0]     b_i,
  output logic [2*upil_pkg::MUL_W-1:0]   prod_o
);

  logic [2*upil_pkg::MUL_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

/* rtl/unicycle_pose_integrator_with_lag.sv */
// top level: unicycle pose integrator with first-order speed lag
//
// usage
//   cmd_i takes one word per item: a tick, a new speed command, a state clear,
//   or the unused code which only reports the state. every accepted word gives
//   exactly one result word on res_o with pose, heading and present speeds.
//   cmd_i.ready is high only while the block is idle; one item at a time.
// sequencing
//   a tick runs the sequencer through its steps, then hands over the result:
//   every product goes through one shared 32x32 multiplier, 20 products per
//   tick (two speed gaps, two 7-product sine evaluations, travel, x, y, turn).
//   commands, clears and the unused code skip the sequencer and go straight
//   to handing over the result.
// reset and stall
//   rst_ni clears the state and loads the register defaults (1 ms tick).
//   a result waits in its registers while res_o.ready is low; no new word is
//   taken until it has gone.
// config port takes writes at any edge with cfg_we_i; use it while idle
module unicycle_pose_integrator_with_lag (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  upil_cmd_if.sink                           cmd_i,
  upil_res_if.source                         res_o,
  input  logic                               cfg_we_i,
  input  logic [upil_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [upil_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned MW = upil_pkg::MUL_W;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // sequencer step numbers
  localparam int unsigned SIN_LEN = 7;
  localparam logic [4:0] S_GAP_LIN  = 5'd0;
  localparam logic [4:0] S_GAP_TURN = 5'd1;
  localparam logic [4:0] S_SIN_A    = 5'd2;
  localparam logic [4:0] S_SIN_B    = 5'(S_SIN_A + SIN_LEN);
  localparam logic [4:0] S_SPD      = 5'(S_SIN_B + SIN_LEN);
  localparam logic [4:0] S_DX       = 5'(S_SPD + 1);
  localparam logic [4:0] S_DY       = 5'(S_SPD + 2);
  localparam logic [4:0] S_ANG      = 5'(S_SPD + 3);
  localparam logic [4:0] S_END      = 5'(S_SPD + 4);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // sine polynomial coefficients, Q2.30 scaled
  function automatic logic [31:0] sin_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = 32'd1686629713;
      3'd1:    c = 32'd693598669;
      3'd2:    c = 32'd85569305;
      3'd3:    c = 32'd5026997;
      3'd4:    c = 32'd172272;
      default: c = 32'd3864;
    endcase
    return c;
  endfunction

  // signed 32-bit accumulate with saturation
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic [24:0] dm,
                                                 input logic neg);
    logic signed [33:0] s;
    logic signed [33:0] d;
    d = $signed({9'd0, dm});
    s = neg ? ({{2{a[31]}}, a} - d) : ({{2{a[31]}}, a} + d);
    if (s > 34'sd2147483647) return 32'sh7fff_ffff;
    if (s < -34'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;

  logic [15:0] decay_q, dead_q;
  logic [23:0] tick_q;

  upil_pkg::lin_t  tgt_lin_q, tgt_lin_d, spd_lin_q, spd_lin_d;
  upil_pkg::turn_t tgt_turn_q, tgt_turn_d, spd_turn_q, spd_turn_d;
  logic [15:0]     ticks_q, ticks_d;
  upil_pkg::pos_t  px_q, px_d, py_q, py_d;
  logic [31:0]     ang_q, ang_d;

  // sequencer scratch
  logic [30:0] sa_q, sa_d, sb_q, sb_d;
  logic [31:0] z_q, z_d, m_q, m_d;

  logic [MW-1:0]   op_a, op_b;
  logic [2*MW-1:0] prod;

  upil_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // speed gaps and their magnitudes
  logic signed [16:0] gap_lin;
  logic signed [24:0] gap_turn;
  logic [16:0] gap_lin_mag;
  logic [24:0] gap_turn_mag;
  logic [16:0] new_lin;
  logic [24:0] new_turn;
  logic        active;
  logic [15:0] spd_lin_mag;
  logic [23:0] spd_turn_mag;

  assign gap_lin      = 17'($signed(tgt_lin_q)) - 17'($signed(spd_lin_q));
  assign gap_turn     = 25'($signed(tgt_turn_q)) - 25'($signed(spd_turn_q));
  assign gap_lin_mag  = gap_lin[16] ? 17'(-gap_lin) : 17'(gap_lin);
  assign gap_turn_mag = gap_turn[24] ? 25'(-gap_turn) : 25'(gap_turn);
  assign new_lin  = gap_lin[16] ? (17'($signed(tgt_lin_q)) + prod[32:16])
                                : (17'($signed(tgt_lin_q)) - prod[32:16]);
  assign new_turn = gap_turn[24] ? (25'($signed(tgt_turn_q)) + prod[40:16])
                                 : (25'($signed(tgt_turn_q)) - prod[40:16]);
  assign active       = ticks_q > dead_q;
  assign spd_lin_mag  = spd_lin_q[15] ? 16'(-spd_lin_q) : 16'(spd_lin_q);
  assign spd_turn_mag = spd_turn_q[23] ? 24'(-spd_turn_q) : 24'(spd_turn_q);

  // sine windows: j is the step inside one evaluation
  logic        in_sin_a, in_sin_b, in_sin;
  logic [4:0]  sin_j_full;
  logic [2:0]  sin_j;
  logic [30:0] sin_u;
  logic [31:0] horner_p;
  logic [31:0] prod_q30;
  logic [30:0] sin_res;

  assign in_sin_a   = (step_q >= S_SIN_A) && (step_q < S_SIN_B);
  assign in_sin_b   = (step_q >= S_SIN_B) && (step_q < S_SPD);
  assign in_sin     = in_sin_a || in_sin_b;
  assign sin_j_full = in_sin_b ? (step_q - S_SIN_B) : (step_q - S_SIN_A);
  assign sin_j      = sin_j_full[2:0];
  assign sin_u      = in_sin_b ? (ONE_Q30 - {1'b0, ang_q[29:0]}) : {1'b0, ang_q[29:0]};
  assign prod_q30   = prod[61:30];
  assign horner_p   = sin_coef(3'(3'd6 - sin_j)) - prod_q30;
  assign sin_res    = (prod_q30 > 32'(ONE_Q30)) ? ONE_Q30 : prod_q30[30:0];

  // quadrant picks sine and cosine magnitudes and signs
  logic [30:0] cm, sm;
  logic        cneg, sneg;
  assign cm   = ang_q[30] ? sa_q : sb_q;
  assign sm   = ang_q[30] ? sb_q : sa_q;
  assign sneg = ang_q[31];
  assign cneg = ang_q[31] ^ ang_q[30];

  logic [48:0] round8;
  assign round8 = prod[48:0] + 49'd128;

  // position step rounded to nearest, q.16 out of q.24 times q1.30
  logic [62:0] round38;
  assign round38 = prod[62:0] + (63'd1 << 37);

  // multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (step_q == S_GAP_LIN) begin
      op_a = MW'(gap_lin_mag);
      op_b = MW'(decay_q);
    end else if (step_q == S_GAP_TURN) begin
      op_a = MW'(gap_turn_mag);
      op_b = MW'(decay_q);
    end else if (in_sin) begin
      if (sin_j == 3'd0) begin
        op_a = MW'(sin_u);
        op_b = MW'(sin_u);
      end else if (sin_j == 3'd1) begin
        op_a = sin_coef(3'd5);
        op_b = prod_q30;
      end else if (sin_j == 3'(SIN_LEN - 1)) begin
        op_a = horner_p;
        op_b = MW'(sin_u);
      end else begin
        op_a = horner_p;
        op_b = z_q;
      end
    end else if (step_q == S_SPD) begin
      op_a = MW'(spd_lin_mag);
      op_b = MW'(tick_q);
    end else if (step_q == S_DX) begin
      op_a = round8[39:8];
      op_b = MW'(cm);
    end else if (step_q == S_DY) begin
      op_a = m_q;
      op_b = MW'(sm);
    end else if (step_q == S_ANG) begin
      op_a = MW'(spd_turn_mag);
      op_b = MW'(tick_q);
    end
  end

  // sequencer and state update
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    tgt_lin_d  = tgt_lin_q;
    tgt_turn_d = tgt_turn_q;
    spd_lin_d  = spd_lin_q;
    spd_turn_d = spd_turn_q;
    ticks_d    = ticks_q;
    px_d       = px_q;
    py_d       = py_q;
    ang_d      = ang_q;
    sa_d       = sa_q;
    sb_d       = sb_q;
    z_d        = z_q;
    m_d        = m_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = ST_DONE;
          unique case (cmd_i.action)
            upil_pkg::ACT_TICK: begin
              state_d = ST_CALC;
              step_d  = S_GAP_LIN;
              if (ticks_q != 16'hffff) ticks_d = ticks_q + 16'd1;
            end
            upil_pkg::ACT_CMD: begin
              tgt_lin_d  = cmd_i.lin_speed_cmd;
              tgt_turn_d = cmd_i.turn_rate_cmd;
              ticks_d    = '0;
            end
            upil_pkg::ACT_CLEAR: begin
              tgt_lin_d  = '0;
              tgt_turn_d = '0;
              spd_lin_d  = '0;
              spd_turn_d = '0;
              ticks_d    = '0;
              px_d       = '0;
              py_d       = '0;
              ang_d      = '0;
            end
            upil_pkg::ACT_NONE: ;
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        step_d = step_q + 5'd1;
        if (step_q == S_GAP_TURN && active) spd_lin_d = new_lin[15:0];
        if (step_q == S_SIN_A && active) spd_turn_d = new_turn[23:0];
        if (in_sin && sin_j == 3'd1) z_d = prod_q30;
        if (step_q == S_SIN_B) sa_d = sin_res;
        if (step_q == S_SPD) sb_d = sin_res;
        if (step_q == S_DX) m_d = round8[39:8];
        if (step_q == S_DY) px_d = sat_add(px_q, round38[62:38], spd_lin_q[15] ^ cneg);
        if (step_q == S_ANG) py_d = sat_add(py_q, round38[62:38], spd_lin_q[15] ^ sneg);
        if (step_q == S_END) begin
          ang_d   = spd_turn_q[23] ? (ang_q - round8[39:8]) : (ang_q + round8[39:8]);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      decay_q    <= '0;
      dead_q     <= '0;
      tick_q     <= 24'd16777;
      tgt_lin_q  <= '0;
      tgt_turn_q <= '0;
      spd_lin_q  <= '0;
      spd_turn_q <= '0;
      ticks_q    <= '0;
      px_q       <= '0;
      py_q       <= '0;
      ang_q      <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      tgt_lin_q  <= tgt_lin_d;
      tgt_turn_q <= tgt_turn_d;
      spd_lin_q  <= spd_lin_d;
      spd_turn_q <= spd_turn_d;
      ticks_q    <= ticks_d;
      px_q       <= px_d;
      py_q       <= py_d;
      ang_q      <= ang_d;
      if (cfg_we_i) begin
        unique case (upil_pkg::cfg_idx_e'(cfg_idx_i))
          upil_pkg::CFG_DECAY: decay_q <= cfg_data_i[15:0];
          upil_pkg::CFG_DEAD:  dead_q  <= cfg_data_i[15:0];
          upil_pkg::CFG_TICK:  tick_q  <= cfg_data_i;
          upil_pkg::CFG_SPARE: ;
          default: ;
        endcase
      end
    end
  end

  // scratch registers, no reset needed
  always_ff @(posedge clk_i) begin
    sa_q <= sa_d;
    sb_q <= sb_d;
    z_q  <= z_d;
    m_q  <= m_d;
  end

  assign cmd_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid         = (state_q == ST_DONE);
  assign res_o.pos_x         = px_q;
  assign res_o.pos_y         = py_q;
  assign res_o.heading       = ang_q;
  assign res_o.lin_speed_now = spd_lin_q;
  assign res_o.turn_rate_now = spd_turn_q;

  // a tick word starts the sequencer at its first step
  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready && cmd_i.action == upil_pkg::ACT_TICK)
      |=> (state_q == ST_CALC && step_q == S_GAP_LIN))
    else $error("tick did not start sequencer");

  // the step counter never runs past the last step
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (step_q <= S_END))
    else $error("sequencer step out of range");

  // pose holds until its own update steps
  a_pose_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && step_q < S_DY) |=> ($stable(px_q) && $stable(ang_q)))
    else $error("pose changed early in tick");

endmodule
